### sv/hsf_pkg.sv
// ----------------------------------------------------------------------------
// hsf_pkg: shared types and constants of the scaled HMM forward block
// Operation codes, controller commands, states and datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

package hsf_pkg;

  localparam int NUM_STATES_DEF  = 8;
  localparam int NUM_SYMBOLS_DEF = 16;
  // Probability format Q0.16, fixed by the width of the probability field
  localparam int PROB_BITS  = 16;
  localparam int SCALE_BITS = 20;
  localparam int LOG_BITS   = 48;
  // Steps of the serial divider and of the log2 fraction loop
  localparam int ITERS      = 16;
  localparam int LN2_Q16    = 45426;

  typedef enum logic [1:0] {
    OP_WR_TRANS = 2'd0,
    OP_WR_EMIS  = 2'd1,
    OP_WR_INIT  = 2'd2,
    OP_OBSERVE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_WRITE,
    CMD_START,
    CMD_MAC,
    CMD_EMUL,
    CMD_CZERO,
    CMD_DIVLD,
    CMD_DIVSTEP,
    CMD_LOGINIT,
    CMD_LOGSTEP,
    CMD_LOGMUL,
    CMD_ACCUM,
    CMD_EMIT
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_EMUL,
    ST_CHECK,
    ST_DIVLD,
    ST_DIV,
    ST_LOGI,
    ST_LOGS,
    ST_LOGM,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e cmd;
  } ctrl_t;

  typedef struct packed {
    logic first;
    logic mac_done;
    logic j_last;
    logic step_last;
    logic c_zero;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### sv/hsf_ram.sv
// ----------------------------------------------------------------------------
// hsf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### sv/hsf_ctrl.sv
// ----------------------------------------------------------------------------
// hsf_ctrl: sequencer of the scaled HMM forward block
// Steps the datapath through accumulate, divide, log and result phases.
// ----------------------------------------------------------------------------
`default_nettype none

module hsf_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            is_obs_i,
  input  wire hsf_pkg::status_t status_i,
  output hsf_pkg::ctrl_t       ctrl_o,
  output logic                 in_ready_o
);

  hsf_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hsf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    ctrl_o.cmd = hsf_pkg::CMD_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      hsf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (is_obs_i) begin
            ctrl_o.cmd = hsf_pkg::CMD_START;
            state_d    = hsf_pkg::ST_MAC;
          end else begin
            ctrl_o.cmd = hsf_pkg::CMD_WRITE;
          end
        end
      end
      hsf_pkg::ST_MAC: begin
        ctrl_o.cmd = hsf_pkg::CMD_MAC;
        if (status_i.first || status_i.mac_done) begin
          state_d = hsf_pkg::ST_EMUL;
        end
      end
      hsf_pkg::ST_EMUL: begin
        ctrl_o.cmd = hsf_pkg::CMD_EMUL;
        state_d    = status_i.j_last ? hsf_pkg::ST_CHECK : hsf_pkg::ST_MAC;
      end
      hsf_pkg::ST_CHECK: begin
        if (status_i.c_zero) begin
          ctrl_o.cmd = hsf_pkg::CMD_CZERO;
          state_d    = hsf_pkg::ST_DONE;
        end else begin
          state_d = hsf_pkg::ST_DIVLD;
        end
      end
      hsf_pkg::ST_DIVLD: begin
        ctrl_o.cmd = hsf_pkg::CMD_DIVLD;
        state_d    = hsf_pkg::ST_DIV;
      end
      hsf_pkg::ST_DIV: begin
        ctrl_o.cmd = hsf_pkg::CMD_DIVSTEP;
        if (status_i.step_last) begin
          state_d = status_i.j_last ? hsf_pkg::ST_LOGI : hsf_pkg::ST_DIVLD;
        end
      end
      hsf_pkg::ST_LOGI: begin
        ctrl_o.cmd = hsf_pkg::CMD_LOGINIT;
        state_d    = hsf_pkg::ST_LOGS;
      end
      hsf_pkg::ST_LOGS: begin
        ctrl_o.cmd = hsf_pkg::CMD_LOGSTEP;
        if (status_i.step_last) begin
          state_d = hsf_pkg::ST_LOGM;
        end
      end
      hsf_pkg::ST_LOGM: begin
        ctrl_o.cmd = hsf_pkg::CMD_LOGMUL;
        state_d    = hsf_pkg::ST_ACC;
      end
      hsf_pkg::ST_ACC: begin
        ctrl_o.cmd = hsf_pkg::CMD_ACCUM;
        state_d    = hsf_pkg::ST_DONE;
      end
      hsf_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          ctrl_o.cmd = hsf_pkg::CMD_EMIT;
          state_d    = hsf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hsf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/hsf_dpath.sv
// ----------------------------------------------------------------------------
// hsf_dpath: datapath of the scaled HMM forward block
// Tables, alpha vector, multiply-accumulate, serial divider, log2 unit and
// the likelihood accumulator with its output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsf_dpath #(
  parameter int NUM_STATES  = hsf_pkg::NUM_STATES_DEF,
  parameter int NUM_SYMBOLS = hsf_pkg::NUM_SYMBOLS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire hsf_pkg::ctrl_t                       ctrl_i,
  output hsf_pkg::status_t                          status_o,
  input  wire logic [1:0]                           operation_i,
  input  wire logic [3:0]                           entry_row_i,
  input  wire logic [3:0]                           entry_col_i,
  input  wire logic [15:0]                          prob_value_i,
  input  wire logic [3:0]                           symbol_i,
  input  wire logic                                 first_i,
  input  wire logic                                 out_ready_i,
  output logic                                      out_valid_o,
  output logic signed [hsf_pkg::LOG_BITS-1:0]       log_likelihood_o,
  output logic [hsf_pkg::SCALE_BITS-1:0]            scale_factor_o,
  output logic                                      zero_likelihood_o
);

  localparam int PB  = hsf_pkg::PROB_BITS;
  localparam int CB  = hsf_pkg::SCALE_BITS;
  localparam int LB  = hsf_pkg::LOG_BITS;
  localparam int SW  = $clog2(NUM_STATES);
  localparam int CW  = $clog2(NUM_STATES + 1);
  localparam int TD  = NUM_STATES * NUM_STATES;
  localparam int ED  = NUM_SYMBOLS * NUM_STATES;
  localparam int TAW = $clog2(TD);
  localparam int EAW = $clog2(ED);
  localparam int AW  = 2 * PB + SW;
  localparam int NW  = $clog2(hsf_pkg::ITERS);
  localparam logic [PB-1:0] PMAX = {PB{1'b1}};
  localparam logic signed [LB-1:0] ACC_MAX = {1'b0, {(LB-1){1'b1}}};
  localparam logic signed [LB-1:0] ACC_MIN = {1'b1, {(LB-1){1'b0}}};

  // Stored state
  logic [PB-1:0]  alpha_q [NUM_STATES];
  logic [PB-1:0]  u_q     [NUM_STATES];
  logic [PB-1:0]  init_q  [NUM_STATES];
  logic signed [LB-1:0] llk_q;
  logic           zero_q;
  logic           out_valid_q;
  logic signed [LB-1:0] out_llk_q;
  logic [CB-1:0]  out_c_q;
  logic           out_zero_q;

  // Working registers
  logic [CW-1:0]  i_q;
  logic [SW-1:0]  j_q;
  logic [AW-1:0]  macc_q;
  logic [CB-1:0]  c_q;
  logic [3:0]     sym_q;
  logic           first_q;
  logic [CB-1:0]  rem_q;
  logic [PB-1:0]  quo_q;
  logic           sat_q;
  logic [NW-1:0]  cnt_q;
  logic [4:0]     k_q;
  logic [30:0]    m_q;
  logic [15:0]    frac_q;
  logic signed [22:0] lnv_q;

  // Table RAM ports
  logic           trans_we, emis_we;
  logic [TAW-1:0] trans_waddr, trans_raddr;
  logic [EAW-1:0] emis_waddr, emis_raddr;
  logic [PB-1:0]  trans_rd, emis_rd;

  logic row_st_ok, col_ok, row_sym_ok, sym_ok;
  logic [SW-1:0]  im1;
  logic [2*PB-1:0] mac_prod;
  logic [PB-1:0]  t_val, e_val;
  logic [2*PB-1:0] te_prod;
  logic [PB-1:0]  u_new;
  logic [CB:0]    c_sum;
  logic [CB:0]    r2;
  logic           ge;
  logic [4:0]     k_c;
  logic [30:0]    m_init;
  logic [61:0]    sq;
  logic [31:0]    mn;
  logic signed [5:0]  kint;
  logic signed [21:0] l2;
  logic [21:0]    mag;
  logic [37:0]    ln_prod;
  logic [22:0]    lm_ext;
  logic signed [LB:0] acc_sum;

  // Decode table writes
  assign row_st_ok  = {1'b0, entry_row_i} < 5'(NUM_STATES);
  assign row_sym_ok = {1'b0, entry_row_i} < 5'(NUM_SYMBOLS);
  assign col_ok     = {1'b0, entry_col_i} < 5'(NUM_STATES);
  assign sym_ok     = {1'b0, sym_q} < 5'(NUM_SYMBOLS);

  assign trans_we = (ctrl_i.cmd == hsf_pkg::CMD_WRITE) &&
                    (operation_i == hsf_pkg::OP_WR_TRANS) && row_st_ok && col_ok;
  assign emis_we  = (ctrl_i.cmd == hsf_pkg::CMD_WRITE) &&
                    (operation_i == hsf_pkg::OP_WR_EMIS) && row_sym_ok && col_ok;
  assign trans_waddr = TAW'(entry_row_i) * TAW'(NUM_STATES) + TAW'(entry_col_i);
  assign emis_waddr  = EAW'(entry_row_i) * EAW'(NUM_STATES) + EAW'(entry_col_i);
  assign trans_raddr = TAW'(i_q[SW-1:0]) * TAW'(NUM_STATES) + TAW'(j_q);
  assign emis_raddr  = EAW'(sym_q) * EAW'(NUM_STATES) + EAW'(j_q);

  hsf_ram #(.WIDTH(PB), .DEPTH(TD)) u_trans_ram (
    .clk_i   (clk_i),
    .we_i    (trans_we),
    .waddr_i (trans_waddr),
    .wdata_i (prob_value_i),
    .raddr_i (trans_raddr),
    .rdata_o (trans_rd)
  );

  hsf_ram #(.WIDTH(PB), .DEPTH(ED)) u_emis_ram (
    .clk_i   (clk_i),
    .we_i    (emis_we),
    .waddr_i (emis_waddr),
    .wdata_i (prob_value_i),
    .raddr_i (emis_raddr),
    .rdata_o (emis_rd)
  );

  // Multiply-accumulate over the previous alpha
  assign im1      = SW'(i_q - CW'(1));
  assign mac_prod = trans_rd * alpha_q[im1];

  // Transition sum (or initial), times emission
  assign t_val   = first_q ? init_q[j_q] :
                   (|macc_q[AW-1:2*PB]) ? PMAX : macc_q[2*PB-1:PB];
  assign e_val   = sym_ok ? emis_rd : '0;
  assign te_prod = t_val * e_val;
  assign u_new   = te_prod[2*PB-1:PB];
  assign c_sum   = {1'b0, c_q} + (CB+1)'(u_new);

  // One restoring division step
  assign r2 = {rem_q, 1'b0};
  assign ge = r2 >= {1'b0, c_q};

  // Leading one of the scale factor
  always_comb begin
    k_c = '0;
    for (int b = 0; b < CB; b++) begin
      if (c_q[b]) begin
        k_c = 5'(b);
      end
    end
  end
  assign m_init = 31'({11'd0, c_q} << (5'd30 - k_c));

  // Squaring step of the log2 fraction
  assign sq = m_q * m_q;
  assign mn = sq[61:30];

  // Scale log2 to natural log, truncating toward zero
  assign kint    = $signed({1'b0, k_q}) - 6'sd16;
  assign l2      = {kint, frac_q};
  assign mag     = l2[21] ? 22'(-l2) : 22'(l2);
  assign ln_prod = mag * 16'(hsf_pkg::LN2_Q16);
  assign lm_ext  = {1'b0, ln_prod[37:16]};

  assign acc_sum = {llk_q[LB-1], llk_q} + (LB+1)'(lnv_q);

  // Control and reset-cleared state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NUM_STATES; n++) begin
        alpha_q[n] <= '0;
      end
      llk_q       <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it once the result is taken
      if (ctrl_i.cmd == hsf_pkg::CMD_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (ctrl_i.cmd)
        hsf_pkg::CMD_START: begin
          if (first_i) begin
            llk_q  <= '0;
            zero_q <= 1'b0;
          end
        end
        hsf_pkg::CMD_CZERO: begin
          for (int n = 0; n < NUM_STATES; n++) begin
            alpha_q[n] <= u_q[n];
          end
          zero_q <= 1'b1;
          llk_q  <= ACC_MIN;
        end
        hsf_pkg::CMD_DIVSTEP: begin
          if (cnt_q == NW'(hsf_pkg::ITERS - 1)) begin
            alpha_q[j_q] <= sat_q ? PMAX : {quo_q[PB-2:0], ge};
          end
        end
        hsf_pkg::CMD_ACCUM: begin
          if (acc_sum[LB] != acc_sum[LB-1]) begin
            llk_q <= acc_sum[LB] ? ACC_MIN : ACC_MAX;
          end else begin
            llk_q <= acc_sum[LB-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers and payload
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.cmd)
      hsf_pkg::CMD_WRITE: begin
        if ((operation_i == hsf_pkg::OP_WR_INIT) && col_ok) begin
          init_q[entry_col_i[SW-1:0]] <= prob_value_i;
        end
      end
      hsf_pkg::CMD_START: begin
        i_q     <= '0;
        j_q     <= '0;
        macc_q  <= '0;
        c_q     <= '0;
        sym_q   <= symbol_i;
        first_q <= first_i;
      end
      hsf_pkg::CMD_MAC: begin
        if (i_q != '0) begin
          macc_q <= macc_q + AW'(mac_prod);
        end
        i_q <= i_q + CW'(1);
      end
      hsf_pkg::CMD_EMUL: begin
        u_q[j_q] <= u_new;
        c_q      <= c_sum[CB] ? {CB{1'b1}} : c_sum[CB-1:0];
        i_q      <= '0;
        macc_q   <= '0;
        j_q      <= (j_q == SW'(NUM_STATES - 1)) ? '0 : j_q + SW'(1);
      end
      hsf_pkg::CMD_DIVLD: begin
        rem_q <= CB'(u_q[j_q]);
        quo_q <= '0;
        cnt_q <= '0;
        sat_q <= CB'(u_q[j_q]) >= c_q;
      end
      hsf_pkg::CMD_DIVSTEP: begin
        rem_q <= ge ? CB'(r2 - {1'b0, c_q}) : CB'(r2);
        quo_q <= {quo_q[PB-2:0], ge};
        cnt_q <= cnt_q + NW'(1);
        if (cnt_q == NW'(hsf_pkg::ITERS - 1)) begin
          j_q <= (j_q == SW'(NUM_STATES - 1)) ? '0 : j_q + SW'(1);
        end
      end
      hsf_pkg::CMD_LOGINIT: begin
        k_q    <= k_c;
        m_q    <= m_init;
        frac_q <= '0;
        cnt_q  <= '0;
      end
      hsf_pkg::CMD_LOGSTEP: begin
        m_q    <= mn[31] ? mn[31:1] : mn[30:0];
        frac_q <= {frac_q[14:0], mn[31]};
        cnt_q  <= cnt_q + NW'(1);
      end
      hsf_pkg::CMD_LOGMUL: begin
        lnv_q <= l2[21] ? $signed(23'(-lm_ext)) : $signed(lm_ext);
      end
      hsf_pkg::CMD_EMIT: begin
        out_llk_q  <= llk_q;
        out_c_q    <= c_q;
        out_zero_q <= zero_q;
      end
      default: begin
      end
    endcase
  end

  // Status to the sequencer
  assign status_o.first     = first_q;
  assign status_o.mac_done  = i_q == CW'(NUM_STATES);
  assign status_o.j_last    = j_q == SW'(NUM_STATES - 1);
  assign status_o.step_last = cnt_q == NW'(hsf_pkg::ITERS - 1);
  assign status_o.c_zero    = c_q == '0;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign log_likelihood_o  = out_llk_q;
  assign scale_factor_o    = out_c_q;
  assign zero_likelihood_o = out_zero_q;

endmodule

`default_nettype wire

### sv/hmm_scaled_forward.sv
// ----------------------------------------------------------------------------
// hmm_scaled_forward: scaled HMM forward pass over observed symbols
// Table writes load transition, emission and initial probabilities; each
// observe request returns scale factor, log-likelihood and zero flag.
// ----------------------------------------------------------------------------
//  channel  signals                      carries
//  in       in_valid_i / in_ready_o      table write or observe request
//  out      out_valid_o / out_ready_i    one result per observe request
//
// A table write is taken in the idle state. An observe request runs the
// serial multiply-accumulate for each state and the 16-step divider
// per state; the first step of a sequence skips the accumulate. The
// result waits in an output register; a stalled output holds the next
// observe request only at its end, before its result is registered.
// Reset clears alpha, the likelihood and the flag; tables hold nothing
// until written.
// ----------------------------------------------------------------------------
`default_nettype none

module hmm_scaled_forward #(
  parameter int NUM_STATES  = hsf_pkg::NUM_STATES_DEF,
  parameter int NUM_SYMBOLS = hsf_pkg::NUM_SYMBOLS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     operation_i,
  input  wire logic [3:0]                     entry_row_i,
  input  wire logic [3:0]                     entry_col_i,
  input  wire logic [15:0]                    prob_value_i,
  input  wire logic [3:0]                     symbol_i,
  input  wire logic                           first_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [hsf_pkg::LOG_BITS-1:0] log_likelihood_o,
  output logic [hsf_pkg::SCALE_BITS-1:0]      scale_factor_o,
  output logic                                zero_likelihood_o
);

  hsf_pkg::ctrl_t   ctrl;
  hsf_pkg::status_t status;

  hsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .is_obs_i   (operation_i == hsf_pkg::OP_OBSERVE),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .in_ready_o (in_ready_o)
  );

  hsf_dpath #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .status_o          (status),
    .operation_i       (operation_i),
    .entry_row_i       (entry_row_i),
    .entry_col_i       (entry_col_i),
    .prob_value_i      (prob_value_i),
    .symbol_i          (symbol_i),
    .first_i           (first_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .log_likelihood_o  (log_likelihood_o),
    .scale_factor_o    (scale_factor_o),
    .zero_likelihood_o (zero_likelihood_o)
  );

endmodule

`default_nettype wire

### sv/hsf_checker.sv
// ----------------------------------------------------------------------------
// hsf_checker: port-level checks of the scaled HMM forward block
// Watches the request and result channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hsf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  operation_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [47:0] log_likelihood_o,
  input wire logic [19:0] scale_factor_o,
  input wire logic        zero_likelihood_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(log_likelihood_o)
      && $stable(scale_factor_o) && $stable(zero_likelihood_o))
    else $error("stalled result changed");

  // Zero scale drives flag and likelihood floor
  a_zero_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (scale_factor_o == 20'd0) |->
      zero_likelihood_o && (log_likelihood_o == {1'b1, 47'd0}))
    else $error("zero scale without flag or floor");

  // Table write never produces a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i != hsf_pkg::OP_OBSERVE) && !out_valid_o
      |=> !out_valid_o)
    else $error("result after table write");

  // Observe request blocks input while at work
  a_obs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i == hsf_pkg::OP_OBSERVE) |=> !in_ready_o)
    else $error("request taken during observe");

endmodule

bind hmm_scaled_forward hsf_checker u_hsf_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .operation_i       (operation_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .log_likelihood_o  (log_likelihood_o),
  .scale_factor_o    (scale_factor_o),
  .zero_likelihood_o (zero_likelihood_o)
);

`default_nettype wire
